// ===== hdl/hcsao_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcsao_pkg
// Types and fixed constants of the height-field contact shadow / AO block.
// ----------------------------------------------------------------------------
package hcsao_pkg;

    // beat payload widths
    localparam int HEIGHT_W   = 16;
    localparam int PIX_W      = 8;
    localparam int AO_W       = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIM_W      = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_DIR_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_DIR_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHADOW_STRENGTH = 3'd4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SHADE = 1'b1;

    // datapath widths, sized for up to 32 march steps
    localparam int POS_W     = 22;  // light direction times step, Q.14
    localparam int STEP_FRAC = 14;
    localparam int CRD_W     = 11;  // signed sample coordinate
    localparam int NEED_W    = 18;  // ray height plus rise
    localparam int NUM_W     = 22;  // weighted excess before the divide
    localparam int A5_W      = 18;  // local rise times four
    localparam int CAP_W     = 17;
    localparam int SHD_W     = 18;
    localparam int V_W       = 20;

    // shared multiplier
    localparam int MUL_A_W   = 22;
    localparam int MUL_B_W   = 21;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;

    localparam logic [POS_W-1:0]  ROUND_HALF   = 22'd8192;
    localparam logic [NEED_W-1:0] STEP_RISE    = 18'd3932;
    localparam logic [AO_W-1:0]   AO_LOCAL_CAP = 16'd26214;
    localparam logic [CAP_W-1:0]  AO_FLOOR     = 17'd9830;
    localparam logic [CAP_W-1:0]  ONE_Q16      = 17'd65536;
    localparam logic [AO_W-1:0]   AO_NONE      = 16'd32768;
    localparam int                RECIP_SHIFT  = 22;
    localparam int                RECIP5_SHIFT = 18;
    localparam logic [MUL_B_W-1:0] RECIP5      = 21'd52428;
    localparam logic [MUL_B_W-1:0] DIV5        = 21'd5;
    localparam int                SHADOW_SHIFT = 15;

    typedef struct packed {
        logic                opcode;
        logic [PIX_W-1:0]    pixel_x;
        logic [PIX_W-1:0]    pixel_y;
        logic [HEIGHT_W-1:0] height_value;
    } t_in_beat;

    typedef struct packed {
        logic [AO_W-1:0]  ao_factor;
        logic [PIX_W-1:0] out_x;
        logic [PIX_W-1:0] out_y;
    } t_out_beat;

    typedef struct packed {
        logic [DIM_W-1:0]        image_width;
        logic [DIM_W-1:0]        image_height;
        logic signed [15:0]      light_dir_x;
        logic signed [15:0]      light_dir_y;
        logic [15:0]             shadow_strength;
    } t_cfg;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

endpackage

// ===== hdl/hcsao_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcsao request / response channels
// Valid/ready channels carrying one input item or one result item a beat.
// ----------------------------------------------------------------------------
interface hcsao_req_if;
    import hcsao_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hcsao_rsp_if;
    import hcsao_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/heightfield_contact_shadow_ao.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_contact_shadow_ao
// Height-field contact shadow and ambient occlusion unit.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries write beats (store a Q0.16 height at pixel x,y) and shade
//   beats (return the Q1.15 occlusion factor of pixel x,y on o_rsp).
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle; unknown indexes are dropped.
//   A write beat gives no result and does not hold off the next beat.
//   A shade beat outside the image goes straight to its result, skipping
//   the march and neighbour scan. Inside the image its time grows with n,
//   the number of march samples read before the border or MARCH_STEPS; it
//   is set by the single height memory read port, one read a cycle, and the
//   one shared multiplier that the march and the final arithmetic both use.
//   i_req is not ready while a shade beat is in work.
//   Results wait in an output register; the block keeps taking beats while
//   it is full, and a following shade result holds in the sequencer until
//   the receiver takes the first one.
//   Reset restores the register defaults and empties the output register.
//   The height memory is not cleared: every pixel read must be written first.
// ----------------------------------------------------------------------------
module heightfield_contact_shadow_ao #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int MARCH_STEPS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    hcsao_req_if.sink                        i_req,
    hcsao_rsp_if.source                      o_rsp,
    input  logic                             i_cfg_we,
    input  logic [hcsao_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hcsao_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hcsao_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    t_cfg                r_cfg;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [HEIGHT_W-1:0] ram_wdata;
    logic [HEIGHT_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width     <= 9'd256;
            r_cfg.image_height    <= 9'd256;
            r_cfg.light_dir_x     <= 16'sd0;
            r_cfg.light_dir_y     <= 16'sd0;
            r_cfg.shadow_strength <= 16'd32768;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:     r_cfg.image_width     <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:    r_cfg.image_height    <= i_cfg_data[DIM_W-1:0];
                CFG_LIGHT_DIR_X:     r_cfg.light_dir_x     <= $signed(i_cfg_data);
                CFG_LIGHT_DIR_Y:     r_cfg.light_dir_y     <= $signed(i_cfg_data);
                CFG_SHADOW_STRENGTH: r_cfg.shadow_strength <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hcsao_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    hcsao_core #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MARCH_STEPS (MARCH_STEPS),
        .ADDR_W      (ADDR_W)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_in_beat   (i_req.data),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_out_beat  (o_rsp.data),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata)
    );
endmodule

// ===== hdl/hcsao_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcsao_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module hcsao_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/hcsao_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcsao_mul
// Shared unsigned multiplier with a registered product, one request a cycle.
// ----------------------------------------------------------------------------
module hcsao_mul (
    input  logic                      i_clk,
    input  hcsao_pkg::t_mul_req       i_req,
    output logic [hcsao_pkg::PROD_W-1:0] o_prod
);
    import hcsao_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
    end

    assign o_prod = r_prod;
endmodule

// ===== hdl/hcsao_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcsao_core
// Sequencer and datapath: height writes, shadow march, neighbour scan and
// the final shading arithmetic on one shared multiplier.
// ----------------------------------------------------------------------------
module hcsao_core #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int MARCH_STEPS = 10,
    parameter int ADDR_W      = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hcsao_pkg::t_cfg               i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  hcsao_pkg::t_in_beat           i_in_beat,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output hcsao_pkg::t_out_beat          o_out_beat,
    output logic                          o_ram_we,
    output logic [ADDR_W-1:0]             o_ram_addr,
    output logic [hcsao_pkg::HEIGHT_W-1:0] o_ram_wdata,
    input  logic [hcsao_pkg::HEIGHT_W-1:0] i_ram_rdata
);
    import hcsao_pkg::*;

    localparam int KDIV   = MARCH_STEPS + 2;
    localparam int SW     = $clog2(MARCH_STEPS + 2);
    localparam int W_LIM  = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
    localparam int H_LIM  = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
    localparam int XW_LIM = (MAX_WIDTH > 256) ? 256 : MAX_WIDTH;
    localparam int YW_LIM = (MAX_HEIGHT > 256) ? 256 : MAX_HEIGHT;

    localparam logic [ADDR_W-1:0]  ROW_STRIDE = ADDR_W'(MAX_WIDTH);
    localparam logic [MUL_B_W-1:0] RECIP_K    = MUL_B_W'((64'd1 << RECIP_SHIFT) / KDIV);
    localparam logic [MUL_B_W-1:0] K_MUL      = MUL_B_W'(KDIV);
    localparam logic [NUM_W-1:0]   K_NUM      = NUM_W'(KDIV);
    localparam logic [SW-1:0]      WT_INIT    = SW'(KDIV - 1);
    localparam logic [SW-1:0]      STEP_LAST  = SW'(MARCH_STEPS);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_H0   = 4'd1;
    localparam logic [3:0] ST_MRD  = 4'd2;
    localparam logic [3:0] ST_MCMP = 4'd3;
    localparam logic [3:0] ST_NB   = 4'd4;
    localparam logic [3:0] ST_DK1  = 4'd5;
    localparam logic [3:0] ST_DK2  = 4'd6;
    localparam logic [3:0] ST_DK3  = 4'd7;
    localparam logic [3:0] ST_D51  = 4'd8;
    localparam logic [3:0] ST_D52  = 4'd9;
    localparam logic [3:0] ST_D53  = 4'd10;
    localparam logic [3:0] ST_SHD1 = 4'd11;
    localparam logic [3:0] ST_SHD2 = 4'd12;
    localparam logic [3:0] ST_DONE = 4'd13;

    // round(p / 2^14) half away from zero, added to the base coordinate
    function automatic logic [CRD_W-1:0] step_coord(input logic [PIX_W-1:0] base,
                                                    input logic [POS_W-1:0] p);
        logic [POS_W-1:0] mag;
        logic [POS_W-1:0] rnd;
        logic [CRD_W-1:0] off;
        logic [CRD_W-1:0] b_ext;
        mag   = p[POS_W-1] ? (~p + POS_W'(1)) : p;
        rnd   = mag + ROUND_HALF;
        off   = CRD_W'(rnd[POS_W-1:STEP_FRAC]);
        b_ext = CRD_W'(base);
        return p[POS_W-1] ? (b_ext - off) : (b_ext + off);
    endfunction

    // control
    logic [3:0]  r_state, n_state;
    logic        r_fold, n_fold;
    logic        r_ov, n_ov;
    // payload
    logic [PIX_W-1:0]    r_x, n_x, r_y, n_y;
    logic [HEIGHT_W-1:0] r_h0, n_h0, r_maxn, n_maxn;
    logic [NEED_W-1:0]   r_need, n_need;
    logic [POS_W-1:0]    r_px, n_px, r_py, n_py;
    logic [SW-1:0]       r_s, n_s, r_wt, n_wt;
    logic [NUM_W-1:0]    r_num, n_num, r_q, n_q, r_occ, n_occ;
    logic [2:0]          r_n, n_n;
    logic [AO_W-1:0]     r_aol, n_aol, r_ao, n_ao;
    t_out_beat           r_ob, n_ob;

    logic                in_acc;
    logic [DIM_W-1:0]    w_img, h_img;
    logic [DIM_W-1:0]    x_ext, y_ext, xp, xm, yp, ym;
    logic [DIM_W-1:0]    rd_cx, rd_cy;
    logic [CRD_W-1:0]    sx, sy;
    logic                step_oob;
    logic                pix_oob;
    logic                wr_ok;
    logic [PROD_W-1:0]   prod;
    t_mul_req            mul_req;
    logic [NEED_W-1:0]   hs_ext;
    logic [NEED_W-1:0]   diff;
    logic [NUM_W-1:0]    q_k, rem_k, q_5, al5;
    logic [A5_W-1:0]     a5, rem_5;
    logic [NUM_W+1:0]    occ3;
    logic [NUM_W+1:0]    occ_half;
    logic [CAP_W-1:0]    cap;
    logic [SHD_W-1:0]    shadow;
    logic signed [V_W-1:0] v;
    logic [CAP_W-1:0]    v_cl;
    logic [CAP_W:0]      ao_rnd;
    logic                out_load;

    hcsao_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    // image size in use, saturated to 1..MAX and to no more than 511
    assign w_img = (i_cfg.image_width == '0) ? DIM_W'(1) :
                   (i_cfg.image_width > DIM_W'(W_LIM)) ? DIM_W'(W_LIM) : i_cfg.image_width;
    assign h_img = (i_cfg.image_height == '0) ? DIM_W'(1) :
                   (i_cfg.image_height > DIM_W'(H_LIM)) ? DIM_W'(H_LIM) : i_cfg.image_height;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    assign pix_oob = (DIM_W'(i_in_beat.pixel_x) >= w_img) ||
                     (DIM_W'(i_in_beat.pixel_y) >= h_img);
    assign wr_ok   = (DIM_W'(i_in_beat.pixel_x) < DIM_W'(XW_LIM)) &&
                     (DIM_W'(i_in_beat.pixel_y) < DIM_W'(YW_LIM));

    assign x_ext = DIM_W'(r_x);
    assign y_ext = DIM_W'(r_y);
    assign xp    = ((x_ext + DIM_W'(1)) >= w_img) ? (w_img - DIM_W'(1)) : (x_ext + DIM_W'(1));
    assign xm    = (x_ext == '0) ? '0 : (x_ext - DIM_W'(1));
    assign yp    = ((y_ext + DIM_W'(1)) >= h_img) ? (h_img - DIM_W'(1)) : (y_ext + DIM_W'(1));
    assign ym    = (y_ext == '0) ? '0 : (y_ext - DIM_W'(1));

    assign sx       = step_coord(r_x, r_px);
    assign sy       = step_coord(r_y, r_py);
    assign step_oob = sx[CRD_W-1] || sy[CRD_W-1] ||
                      (sx >= CRD_W'(w_img)) || (sy >= CRD_W'(h_img));

    assign hs_ext = NEED_W'(i_ram_rdata);
    assign diff   = hs_ext - r_need;

    // floor(a / K) and floor(a / 5) by reciprocal, then one correction
    assign q_k   = NUM_W'(prod >> RECIP_SHIFT);
    assign rem_k = r_num - prod[NUM_W-1:0];
    assign a5    = {r_maxn - r_h0, 2'b00};
    assign q_5   = NUM_W'(prod >> RECIP5_SHIFT);
    assign rem_5 = a5 - prod[A5_W-1:0];
    assign al5   = r_q + NUM_W'(rem_5 >= A5_W'(DIV5));

    assign occ3     = (NUM_W+2)'({r_occ, 1'b0}) + (NUM_W+2)'(r_occ);
    assign occ_half = occ3 >> 1;
    assign cap      = (occ_half > (NUM_W+2)'(ONE_Q16)) ? ONE_Q16 : CAP_W'(occ_half);

    assign shadow = prod[SHADOW_SHIFT +: SHD_W];
    assign v      = $signed(V_W'(ONE_Q16)) - $signed(V_W'(shadow)) - $signed(V_W'(r_aol));
    assign v_cl   = (v < $signed(V_W'(AO_FLOOR))) ? AO_FLOOR :
                    (v > $signed(V_W'(ONE_Q16))) ? ONE_Q16 : CAP_W'(v);
    assign ao_rnd = (CAP_W+1)'(v_cl) + (CAP_W+1)'(1);

    assign out_load = (r_state == ST_DONE) && (!r_ov || i_out_ready);

    // one memory address a cycle: write, centre, march sample or neighbour
    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                rd_cx = DIM_W'(i_in_beat.pixel_x);
                rd_cy = DIM_W'(i_in_beat.pixel_y);
            end
            ST_MRD: begin
                rd_cx = sx[DIM_W-1:0];
                rd_cy = sy[DIM_W-1:0];
            end
            ST_NB: begin
                unique case (r_n[1:0])
                    2'd0: begin rd_cx = xp;    rd_cy = y_ext; end
                    2'd1: begin rd_cx = xm;    rd_cy = y_ext; end
                    2'd2: begin rd_cx = x_ext; rd_cy = yp;    end
                    2'd3: begin rd_cx = x_ext; rd_cy = ym;    end
                endcase
            end
            default: begin
                rd_cx = x_ext;
                rd_cy = y_ext;
            end
        endcase
    end

    assign o_ram_addr  = ADDR_W'(rd_cy) * ROW_STRIDE + ADDR_W'(rd_cx);
    assign o_ram_wdata = i_in_beat.height_value;
    assign o_ram_we    = in_acc && (i_in_beat.opcode == OP_WRITE) && wr_ok;

    always_comb begin
        n_state = r_state;
        n_fold  = 1'b0;
        n_ov    = r_ov && !i_out_ready;
        n_x     = r_x;
        n_y     = r_y;
        n_h0    = r_h0;
        n_maxn  = r_maxn;
        n_need  = r_need;
        n_px    = r_px;
        n_py    = r_py;
        n_s     = r_s;
        n_wt    = r_wt;
        n_num   = r_num;
        n_q     = r_q;
        n_occ   = r_occ;
        n_n     = r_n;
        n_aol   = r_aol;
        n_ao    = r_ao;
        n_ob    = r_ob;
        mul_req = '0;

        // fold the weighted excess issued the cycle before
        if (r_fold && (prod[NUM_W-1:0] > r_num)) begin
            n_num = prod[NUM_W-1:0];
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in_beat.opcode == OP_SHADE)) begin
                    n_x   = i_in_beat.pixel_x;
                    n_y   = i_in_beat.pixel_y;
                    n_px  = POS_W'(i_cfg.light_dir_x);
                    n_py  = POS_W'(i_cfg.light_dir_y);
                    n_s   = SW'(1);
                    n_wt  = WT_INIT;
                    n_num = '0;
                    if (pix_oob) begin
                        n_ao    = AO_NONE;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_H0;
                    end
                end
            end
            ST_H0: begin
                n_h0    = i_ram_rdata;
                n_maxn  = i_ram_rdata;
                n_need  = NEED_W'(i_ram_rdata) + STEP_RISE;
                n_state = ST_MRD;
            end
            ST_MRD: begin
                if ((r_s > STEP_LAST) || step_oob) begin
                    n_n     = '0;
                    n_state = ST_NB;
                end else begin
                    n_state = ST_MCMP;
                end
            end
            ST_MCMP: begin
                if (hs_ext > r_need) begin
                    mul_req.a = MUL_A_W'(diff[HEIGHT_W-1:0]);
                    mul_req.b = MUL_B_W'(r_wt);
                    n_fold    = 1'b1;
                end
                n_s     = r_s + SW'(1);
                n_wt    = r_wt - SW'(1);
                n_need  = r_need + STEP_RISE;
                n_px    = r_px + POS_W'(i_cfg.light_dir_x);
                n_py    = r_py + POS_W'(i_cfg.light_dir_y);
                n_state = ST_MRD;
            end
            ST_NB: begin
                // read issued for r_n, data of the previous neighbour arrives
                if ((r_n != '0) && (i_ram_rdata > r_maxn)) begin
                    n_maxn = i_ram_rdata;
                end
                n_n = r_n + 3'd1;
                if (r_n == 3'd4) begin
                    n_state = ST_DK1;
                end
            end
            ST_DK1: begin
                mul_req.a = MUL_A_W'(r_num);
                mul_req.b = RECIP_K;
                n_state   = ST_DK2;
            end
            ST_DK2: begin
                n_q       = q_k;
                mul_req.a = MUL_A_W'(q_k);
                mul_req.b = K_MUL;
                n_state   = ST_DK3;
            end
            ST_DK3: begin
                n_occ   = r_q + NUM_W'(rem_k >= K_NUM);
                n_state = ST_D51;
            end
            ST_D51: begin
                mul_req.a = MUL_A_W'(a5);
                mul_req.b = RECIP5;
                n_state   = ST_D52;
            end
            ST_D52: begin
                n_q       = q_5;
                mul_req.a = MUL_A_W'(q_5);
                mul_req.b = DIV5;
                n_state   = ST_D53;
            end
            ST_D53: begin
                n_aol   = (al5 > NUM_W'(AO_LOCAL_CAP)) ? AO_LOCAL_CAP : AO_W'(al5);
                n_state = ST_SHD1;
            end
            ST_SHD1: begin
                mul_req.a = MUL_A_W'(cap);
                mul_req.b = MUL_B_W'(i_cfg.shadow_strength);
                n_state   = ST_SHD2;
            end
            ST_SHD2: begin
                n_ao    = ao_rnd[AO_W:1];
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    n_ov              = 1'b1;
                    n_ob.ao_factor    = r_ao;
                    n_ob.out_x        = r_x;
                    n_ob.out_y        = r_y;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fold  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fold  <= n_fold;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_h0   <= n_h0;
        r_maxn <= n_maxn;
        r_need <= n_need;
        r_px   <= n_px;
        r_py   <= n_py;
        r_s    <= n_s;
        r_wt   <= n_wt;
        r_num  <= n_num;
        r_q    <= n_q;
        r_occ  <= n_occ;
        r_n    <= n_n;
        r_aol  <= n_aol;
        r_ao   <= n_ao;
        r_ob   <= n_ob;
    end

    assign o_out_valid = r_ov;
    assign o_out_beat  = r_ob;
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the height-field contact shadow / AO unit. A queue
// of write and shade beats feeds a clocked driver; every accepted beat runs
// through a local height store and shade predictor, and a clocked monitor
// compares each result beat with the oldest predicted one. Phases change
// the image size, light direction and shadow strength, and throttle both
// channels in several ways, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import hcsao_pkg::*;

    localparam int MAX_W          = 256;
    localparam int MAX_H          = 256;
    localparam int STEPS          = 10;
    localparam int TAIL_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;

    // indexes past the register list, dropped by the block
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST  = 3'd7;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    hcsao_req_if req_ch ();
    hcsao_rsp_if rsp_ch ();

    heightfield_contact_shadow_ao #(
        .MAX_WIDTH   (MAX_W),
        .MAX_HEIGHT  (MAX_H),
        .MARCH_STEPS (STEPS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // local copy of the block's state
    bit [HEIGHT_W-1:0] height_mem [0:MAX_W*MAX_H-1];
    bit                height_written [0:MAX_W*MAX_H-1];
    t_cfg              cfg_shadow;
    int                touched_addr [$];

    t_in_beat  pending_q [$];
    t_out_beat ao_expected_q [$];
    t_out_beat ao_want;
    t_out_beat ao_head;

    int send_idle_pct;
    int rsp_stall_pct;
    int rsp_hold_cycles;
    int mismatches;
    int quiet_cycles;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // round(d * s / 2^14), half away from zero
    function automatic int march_offset(int d, int s);
        int p;
        p = d * s;
        if (p >= 0) return (p + int'(ROUND_HALF)) >> STEP_FRAC;
        return -(((-p) + int'(ROUND_HALF)) >> STEP_FRAC);
    endfunction

    // every read is logged so the stimulus can write the pixels first
    function automatic longint height_at(int x, int y);
        touched_addr.push_back(y * MAX_W + x);
        return longint'(height_mem[y * MAX_W + x]);
    endfunction

    function automatic logic [AO_W-1:0] predict_ao(int x, int y);
        int     w, h, lx, ly, s, sx, sy, n, nx, ny;
        longint k, h0, hs, need, e, occ, max_n, hn, ao_loc, cap, shd, v;
        touched_addr.delete();
        w = clamp_int(int'(cfg_shadow.image_width), 1, MAX_W);
        h = clamp_int(int'(cfg_shadow.image_height), 1, MAX_H);
        if (x >= w || y >= h) return AO_NONE;
        lx    = int'($signed(cfg_shadow.light_dir_x));
        ly    = int'($signed(cfg_shadow.light_dir_y));
        k     = STEPS + 2;
        occ   = 0;
        h0    = height_at(x, y);
        max_n = h0;
        for (s = 1; s <= STEPS; s++) begin
            sx = x + march_offset(lx, s);
            sy = y + march_offset(ly, s);
            if (sx < 0 || sy < 0 || sx >= w || sy >= h) break;
            hs   = height_at(sx, sy);
            need = h0 + longint'(STEP_RISE) * s;
            if (hs > need) begin
                e = (hs - need) * (k - s) / k;
                if (e > occ) occ = e;
            end
        end
        for (n = 0; n < 4; n++) begin
            nx = clamp_int(x + ((n == 0) ? 1 : (n == 1) ? -1 : 0), 0, w - 1);
            ny = clamp_int(y + ((n == 2) ? 1 : (n == 3) ? -1 : 0), 0, h - 1);
            hn = height_at(nx, ny);
            if (hn > max_n) max_n = hn;
        end
        ao_loc = (max_n - h0) * 4 / 5;
        if (ao_loc > longint'(AO_LOCAL_CAP)) ao_loc = longint'(AO_LOCAL_CAP);
        cap = occ * 3 / 2;
        if (cap > longint'(ONE_Q16)) cap = longint'(ONE_Q16);
        shd = (cap * longint'(cfg_shadow.shadow_strength)) >> SHADOW_SHIFT;
        v   = longint'(ONE_Q16) - shd - ao_loc;
        if (v < longint'(AO_FLOOR)) v = longint'(AO_FLOOR);
        if (v > longint'(ONE_Q16)) v = longint'(ONE_Q16);
        return AO_W'((v + 1) >> 1);
    endfunction

    function automatic logic [HEIGHT_W-1:0] pick_height();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return HEIGHT_W'($urandom_range(65535));
        endcase
    endfunction

    task automatic push_write(int x, int y, logic [HEIGHT_W-1:0] hv);
        t_in_beat b;
        b.opcode       = OP_WRITE;
        b.pixel_x      = PIX_W'(x);
        b.pixel_y      = PIX_W'(y);
        b.height_value = hv;
        pending_q.push_back(b);
        height_written[y * MAX_W + x] = 1'b1;
    endtask

    // a shade beat, preceded by writes of any pixel it would read unwritten
    task automatic push_shade(int x, int y);
        t_in_beat b;
        int       reads [$];
        void'(predict_ao(x, y));
        reads = touched_addr;
        foreach (reads[i]) begin
            if (!height_written[reads[i]])
                push_write(reads[i] % MAX_W, reads[i] / MAX_W, pick_height());
        end
        b.opcode       = OP_SHADE;
        b.pixel_x      = PIX_W'(x);
        b.pixel_y      = PIX_W'(y);
        b.height_value = HEIGHT_W'($urandom_range(65535));
        pending_q.push_back(b);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_IMAGE_WIDTH:     cfg_shadow.image_width     = val[DIM_W-1:0];
            CFG_IMAGE_HEIGHT:    cfg_shadow.image_height    = val[DIM_W-1:0];
            CFG_LIGHT_DIR_X:     cfg_shadow.light_dir_x     = val;
            CFG_LIGHT_DIR_Y:     cfg_shadow.light_dir_y     = val;
            CFG_SHADOW_STRENGTH: cfg_shadow.shadow_strength = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(int w, int h, int lx, int ly, int strength);
        cfg_write(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        cfg_write(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        cfg_write(CFG_LIGHT_DIR_X, CFG_DATA_W'(lx));
        cfg_write(CFG_LIGHT_DIR_Y, CFG_DATA_W'(ly));
        cfg_write(CFG_SHADOW_STRENGTH, CFG_DATA_W'(strength));
        @(negedge i_clk);
    endtask

    task automatic set_idling(t_idle_mode mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 76; rsp_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  rsp_stall_pct = 76; end
            IDLE_BOTH:     begin send_idle_pct = 7;  rsp_stall_pct = 7;  end
            default:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        endcase
    endtask

    // sender pause: nothing queued, nothing on the bus, every result back
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_q.size() != 0 || req_ch.valid || ao_expected_q.size() != 0 ||
               rsp_hold_cycles != 0)
            @(negedge i_clk);
        // writes give no result and may still be in work
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(int w, int h, int lx, int ly, int strength,
                             t_idle_mode mode, int n_items, int hold);
        int ew, eh, win_w, win_h, x0, y0, i;
        set_config(w, h, lx, ly, strength);
        set_idling(mode);
        ew    = clamp_int(w & 32'h1ff, 1, MAX_W);
        eh    = clamp_int(h & 32'h1ff, 1, MAX_H);
        win_w = (ew < 24) ? ew : 24;
        win_h = (eh < 24) ? eh : 24;
        x0    = $urandom_range(ew - win_w);
        y0    = $urandom_range(eh - win_h);
        if (hold > 0) rsp_hold_cycles = hold;
        for (i = 0; i < n_items; i++) begin
            if (hold > 0 && i == n_items / 2) wait_drained();
            if ($urandom_range(99) < 45) begin
                if ($urandom_range(99) < 70)
                    push_write(x0 + $urandom_range(win_w - 1), y0 + $urandom_range(win_h - 1),
                               pick_height());
                else
                    push_write($urandom_range(255), $urandom_range(255), pick_height());
            end else begin
                if ($urandom_range(99) < 85)
                    push_shade(x0 + $urandom_range(win_w - 1), y0 + $urandom_range(win_h - 1));
                else
                    push_shade($urandom_range(255), $urandom_range(255));
            end
        end
        wait_drained();
    endtask

    // driver: one beat from the queue, prediction taken at acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                if (req_ch.data.opcode == OP_WRITE) begin
                    // 8-bit coordinates always land inside the store
                    height_mem[{req_ch.data.pixel_y, req_ch.data.pixel_x}] =
                        req_ch.data.height_value;
                end else begin
                    ao_want.ao_factor = predict_ao(int'(req_ch.data.pixel_x),
                                                   int'(req_ch.data.pixel_y));
                    ao_want.out_x     = req_ch.data.pixel_x;
                    ao_want.out_y     = req_ch.data.pixel_y;
                    ao_expected_q.push_back(ao_want);
                end
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_ch.data  <= pending_q.pop_front();
                    req_ch.valid <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: result check and receiver throttling
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (ao_expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result beat ao=%0d x=%0d y=%0d",
                                 rsp_ch.data.ao_factor, rsp_ch.data.out_x, rsp_ch.data.out_y);
                end else begin
                    ao_head = ao_expected_q.pop_front();
                    if (rsp_ch.data.ao_factor !== ao_head.ao_factor ||
                        rsp_ch.data.out_x !== ao_head.out_x ||
                        rsp_ch.data.out_y !== ao_head.out_y) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("result mismatch: exp ao=%0d x=%0d y=%0d, got ao=%0d x=%0d y=%0d",
                                     ao_head.ao_factor, ao_head.out_x, ao_head.out_y,
                                     rsp_ch.data.ao_factor, rsp_ch.data.out_x,
                                     rsp_ch.data.out_y);
                    end
                end
            end
            if (rsp_hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_cycles--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    // watchdog on cycles without any beat moving
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int p;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        req_ch.valid    = 1'b0;
        req_ch.data     = '0;
        rsp_ch.ready    = 1'b0;
        send_idle_pct   = 0;
        rsp_stall_pct   = 0;
        rsp_hold_cycles = 0;
        mismatches      = 0;
        cfg_shadow.image_width     = 9'd256;
        cfg_shadow.image_height    = 9'd256;
        cfg_shadow.light_dir_x     = '0;
        cfg_shadow.light_dir_y     = '0;
        cfg_shadow.shadow_strength = 16'd32768;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register defaults: zero light, local occlusion at its cap, far corner
        push_write(0, 0, 16'h0000);
        push_write(1, 0, 16'hffff);
        push_write(0, 1, 16'h0000);
        push_shade(0, 0);
        push_write(255, 255, 16'hffff);
        push_write(254, 255, 16'h0000);
        push_write(255, 254, 16'h0000);
        push_shade(255, 255);
        wait_drained();

        // tall blocker next door at full strength drives the factor to its floor
        set_config(4, 4, 16384, 0, 65535);
        push_write(1, 1, 16'h0000);
        push_write(2, 1, 16'hffff);
        push_shade(1, 1);
        push_shade(9, 2);
        push_shade(3, 3);
        wait_drained();

        // zero size saturates to one pixel, unnormalised light, spare indexes
        set_config(0, 0, -32768, 32767, 0);
        cfg_write(CFG_IDX_SPARE, 16'h0001);
        cfg_write(CFG_IDX_LAST, 16'hffff);
        @(negedge i_clk);
        push_shade(0, 0);
        push_shade(1, 0);
        push_shade(0, 255);
        wait_drained();

        // oversize image saturates to the store, march leaves through the top
        set_config(511, 511, 0, -16384, 65535);
        push_shade(10, 0);
        push_write(10, 200, 16'h0000);
        push_write(10, 199, 16'hffff);
        push_shade(10, 200);
        wait_drained();

        run_phase(16, 16, 16384, 0, 32768, IDLE_NONE, 150, 0);
        run_phase(256, 256, -11585, 11585, 65535, IDLE_SENDER, 80, 0);
        run_phase(1, 20, 0, 16384, 0, IDLE_RECEIVER, 80, 0);
        run_phase(33, 7, -32768, 32767, 65535, IDLE_BOTH, 120, 0);
        // receiver holds off long enough for the input to back up
        run_phase(8, 8, 5000, -15000, 40000, IDLE_NONE, 60, 400);
        for (p = 0; p < 4; p++)
            run_phase($urandom_range(48, 1), $urandom_range(48, 1),
                      int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                      $urandom_range(65535), t_idle_mode'(p), 100, 0);
        run_phase(256, 3, 16384, -16384, 65535, IDLE_BOTH, 60, 0);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
